@@ hdl/scba_pkg.sv @@
// Shared constants, types and helpers for the size-class buffer pool allocator.
`timescale 1ns / 1ps

package scba_pkg;

    localparam int SMALL_SLOTS  = 256;
    localparam int MEDIUM_SLOTS = 64;
    localparam int LARGE_SLOTS  = 16;

    localparam int NUM_POOLS = 3;
    localparam int POOL_W    = 2;
    localparam int SLOT_W    = 8;
    localparam int CNT_W     = 9;
    localparam int SIZE_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    // busy bits are scanned one 16-bit word per cycle
    localparam int LANE_N = 16;
    localparam int LANE_W = 4;
    localparam int WSEL_W = SLOT_W - LANE_W;

    localparam int SMALL_WORDS  = (SMALL_SLOTS + LANE_N - 1) / LANE_N;
    localparam int MEDIUM_WORDS = (MEDIUM_SLOTS + LANE_N - 1) / LANE_N;
    localparam int LARGE_WORDS  = (LARGE_SLOTS + LANE_N - 1) / LANE_N;
    localparam int TOTAL_WORDS  = SMALL_WORDS + MEDIUM_WORDS + LARGE_WORDS;
    localparam int WADDR_W      = $clog2(TOTAL_WORDS);

    localparam logic [POOL_W-1:0] POOL_SMALL  = 2'd0;
    localparam logic [POOL_W-1:0] POOL_MEDIUM = 2'd1;
    localparam logic [POOL_W-1:0] POOL_LARGE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DISABLED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SLOT_IDLE  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_LIMIT  = 2'd3;

    localparam logic [SIZE_W-1:0] SMALL_LIMIT_RST  = 32'd4096;
    localparam logic [SIZE_W-1:0] MEDIUM_LIMIT_RST = 32'd65536;
    localparam logic [SIZE_W-1:0] LARGE_LIMIT_RST  = 32'd1048576;

    typedef struct packed {
        logic                            enabled;
        logic [NUM_POOLS-1:0][SIZE_W-1:0] limit;
    } cfg_t;

    function automatic logic [CNT_W-1:0] pool_slots(input logic [POOL_W-1:0] p);
        logic [CNT_W-1:0] n;
        case (p)
            POOL_SMALL:  n = CNT_W'(SMALL_SLOTS);
            POOL_MEDIUM: n = CNT_W'(MEDIUM_SLOTS);
            POOL_LARGE:  n = CNT_W'(LARGE_SLOTS);
            default:     n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [WADDR_W-1:0] pool_base(input logic [POOL_W-1:0] p);
        logic [WADDR_W-1:0] b;
        case (p)
            POOL_SMALL:  b = '0;
            POOL_MEDIUM: b = WADDR_W'(SMALL_WORDS);
            POOL_LARGE:  b = WADDR_W'(SMALL_WORDS + MEDIUM_WORDS);
            default:     b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [WSEL_W-1:0] pool_last_word(input logic [POOL_W-1:0] p);
        logic [WSEL_W-1:0] w;
        case (p)
            POOL_SMALL:  w = WSEL_W'(SMALL_WORDS - 1);
            POOL_MEDIUM: w = WSEL_W'(MEDIUM_WORDS - 1);
            POOL_LARGE:  w = WSEL_W'(LARGE_WORDS - 1);
            default:     w = '0;
        endcase
        return w;
    endfunction

    // lanes of word w that map to real slots of pool p
    function automatic logic [LANE_N-1:0] word_mask(input logic [POOL_W-1:0] p,
                                                   input logic [WSEL_W-1:0] w);
        logic [LANE_N-1:0] m;
        int                lim;
        lim = int'(pool_slots(p));
        for (int b = 0; b < LANE_N; b++)
        begin
            m[b] = ((int'(w) * LANE_N + b) < lim);
        end
        return m;
    endfunction

endpackage

@@ hdl/size_class_buffer_pool_allocator.sv @@
// Allocate: done follows the enable check in S_CLASS, the limit compares in turn (up to 3),
// then one 16-slot busy word per cycle through the shared scanner.
// Free: the S_FREE state does one busy word lookup and done is registered from it.
// busy drops in the cycle done is high, so the next request is taken at the edge ending
// it; the receiver cannot stall results.
// Reset (async, active low) frees all slots, zeroes counts, restores default config.
`timescale 1ns / 1ps

module size_class_buffer_pool_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           opcode,
    input  logic [scba_pkg::SIZE_W-1:0]    request_size,
    input  logic [scba_pkg::POOL_W-1:0]    free_pool,
    input  logic [scba_pkg::SLOT_W-1:0]    free_slot,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scba_pkg::SIZE_W-1:0]    cfg_data,
    output logic                           done,
    output logic [scba_pkg::STATUS_W-1:0]  status,
    output logic [scba_pkg::POOL_W-1:0]    pool,
    output logic [scba_pkg::SLOT_W-1:0]    slot,
    output logic [scba_pkg::CNT_W-1:0]     pool_in_use,
    output logic [scba_pkg::CNT_W-1:0]     pool_free
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLASS = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FREE  = 2'd3;

    scba_pkg::cfg_t cfg;

    logic [1:0]                    state_reg, state_next;
    logic                          op_reg;
    logic [scba_pkg::SIZE_W-1:0]   size_reg;
    logic [scba_pkg::POOL_W-1:0]   fp_reg;
    logic [scba_pkg::SLOT_W-1:0]   fs_reg;
    logic [scba_pkg::POOL_W-1:0]   k_reg, k_next;
    logic [scba_pkg::POOL_W-1:0]   pool_reg, pool_next;
    logic [scba_pkg::WSEL_W-1:0]   w_reg, w_next;

    logic [scba_pkg::LANE_N-1:0]   busy_reg [scba_pkg::TOTAL_WORDS];
    logic [scba_pkg::CNT_W-1:0]    count_reg [scba_pkg::NUM_POOLS];

    logic                          done_reg, done_next;
    logic [scba_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [scba_pkg::POOL_W-1:0]   res_pool_reg, res_pool_next;
    logic [scba_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [scba_pkg::CNT_W-1:0]    res_in_use_reg, res_in_use_next;
    logic [scba_pkg::CNT_W-1:0]    res_free_reg, res_free_next;

    logic [scba_pkg::POOL_W-1:0]   act_pool;
    logic [scba_pkg::WADDR_W-1:0]  rd_addr;
    logic [scba_pkg::LANE_N-1:0]   rd_word;
    logic [scba_pkg::LANE_N-1:0]   scan_mask;
    logic                          scan_found;
    logic [scba_pkg::LANE_W-1:0]   scan_idx;
    logic [scba_pkg::LANE_W-1:0]   wr_lane;
    logic                          wr_en, wr_val;
    logic                          cnt_inc, cnt_dec;
    logic [scba_pkg::CNT_W-1:0]    cur_count;
    logic [scba_pkg::CNT_W-1:0]    cur_slots;
    logic [scba_pkg::CNT_W-1:0]    em_used;
    logic                          em_counts;

    scba_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scba_scan u_scan (
        .word  (rd_word),
        .mask  (scan_mask),
        .found (scan_found),
        .idx   (scan_idx)
    );

    assign act_pool  = (state_reg == S_FREE) ? fp_reg : pool_reg;
    assign cur_slots = scba_pkg::pool_slots(act_pool);
    assign cur_count = (act_pool < scba_pkg::POOL_W'(scba_pkg::NUM_POOLS))
                       ? count_reg[act_pool] : '0;

    always_comb
    begin
        if (state_reg == S_FREE)
            rd_addr = scba_pkg::pool_base(fp_reg)
                      + scba_pkg::WADDR_W'(fs_reg[scba_pkg::SLOT_W-1:scba_pkg::LANE_W]);
        else
            rd_addr = scba_pkg::pool_base(pool_reg) + scba_pkg::WADDR_W'(w_reg);
    end

    // bad handles can point past the store; the lookup result is unused then
    assign rd_word   = (int'(rd_addr) < scba_pkg::TOTAL_WORDS) ? busy_reg[rd_addr] : '0;
    assign scan_mask = scba_pkg::word_mask(pool_reg, w_reg);
    assign wr_lane   = (state_reg == S_FREE) ? fs_reg[scba_pkg::LANE_W-1:0] : scan_idx;

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        pool_next       = pool_reg;
        w_next          = w_reg;
        done_next       = 1'b0;
        res_status_next = res_status_reg;
        res_pool_next   = res_pool_reg;
        res_slot_next   = res_slot_reg;
        wr_en           = 1'b0;
        wr_val          = 1'b0;
        cnt_inc         = 1'b0;
        cnt_dec         = 1'b0;
        em_counts       = 1'b0;
        em_used         = cur_count;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    k_next     = '0;
                    state_next = opcode ? S_FREE : S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (!cfg.enabled)
                begin
                    done_next       = 1'b1;
                    res_status_next = scba_pkg::ST_DISABLED;
                    res_pool_next   = '0;
                    res_slot_next   = '0;
                end
                else if (size_reg <= cfg.limit[k_reg])
                begin
                    pool_next  = k_reg;
                    w_next     = '0;
                    state_next = S_SCAN;
                end
                else if (k_reg == scba_pkg::POOL_W'(scba_pkg::NUM_POOLS - 1))
                begin
                    done_next       = 1'b1;
                    res_status_next = scba_pkg::ST_TOO_LARGE;
                    res_pool_next   = '0;
                    res_slot_next   = '0;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (scan_found)
                begin
                    wr_en           = 1'b1;
                    wr_val          = 1'b1;
                    cnt_inc         = 1'b1;
                    done_next       = 1'b1;
                    em_counts       = 1'b1;
                    em_used         = cur_count + 1'b1;
                    res_status_next = scba_pkg::ST_GRANTED;
                    res_pool_next   = pool_reg;
                    res_slot_next   = {w_reg, scan_idx};
                end
                else if (w_reg == scba_pkg::pool_last_word(pool_reg))
                begin
                    done_next       = 1'b1;
                    em_counts       = 1'b1;
                    res_status_next = scba_pkg::ST_EXHAUSTED;
                    res_pool_next   = pool_reg;
                    res_slot_next   = '0;
                end
                else
                begin
                    w_next = w_reg + 1'b1;
                end
            end
            S_FREE:
            begin
                done_next = 1'b1;
                if (fp_reg >= scba_pkg::POOL_W'(scba_pkg::NUM_POOLS))
                begin
                    res_status_next = scba_pkg::ST_BAD_HANDLE;
                    res_pool_next   = '0;
                    res_slot_next   = '0;
                end
                else if (scba_pkg::CNT_W'(fs_reg) >= cur_slots)
                begin
                    em_counts       = 1'b1;
                    res_status_next = scba_pkg::ST_BAD_HANDLE;
                    res_pool_next   = fp_reg;
                    res_slot_next   = '0;
                end
                else if (!rd_word[fs_reg[scba_pkg::LANE_W-1:0]])
                begin
                    em_counts       = 1'b1;
                    res_status_next = scba_pkg::ST_SLOT_IDLE;
                    res_pool_next   = fp_reg;
                    res_slot_next   = fs_reg;
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_val          = 1'b0;
                    cnt_dec         = (cur_count != '0);
                    em_counts       = 1'b1;
                    em_used         = (cur_count != '0) ? cur_count - 1'b1 : cur_count;
                    res_status_next = scba_pkg::ST_RELEASED;
                    res_pool_next   = fp_reg;
                    res_slot_next   = fs_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
            state_next = S_IDLE;

        res_in_use_next = em_counts ? em_used : '0;
        res_free_next   = em_counts ? (cur_slots - em_used) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
            pool_reg  <= '0;
            w_reg     <= '0;
            for (int i = 0; i < scba_pkg::TOTAL_WORDS; i++)
            begin
                busy_reg[i] <= '0;
            end
            for (int p = 0; p < scba_pkg::NUM_POOLS; p++)
            begin
                count_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            k_reg     <= k_next;
            pool_reg  <= pool_next;
            w_reg     <= w_next;
            if (wr_en)
                busy_reg[rd_addr][wr_lane] <= wr_val;
            if (cnt_inc)
                count_reg[act_pool] <= cur_count + 1'b1;
            else if (cnt_dec)
                count_reg[act_pool] <= cur_count - 1'b1;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg   <= opcode;
            size_reg <= request_size;
            fp_reg   <= free_pool;
            fs_reg   <= free_slot;
        end
        res_status_reg <= res_status_next;
        res_pool_reg   <= res_pool_next;
        res_slot_reg   <= res_slot_next;
        res_in_use_reg <= res_in_use_next;
        res_free_reg   <= res_free_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = res_status_reg;
    assign pool        = res_pool_reg;
    assign slot        = res_slot_reg;
    assign pool_in_use = res_in_use_reg;
    assign pool_free   = res_free_reg;

`ifndef SYNTHESIS
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE))
        else $error("done without a request in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[0] <= scba_pkg::CNT_W'(scba_pkg::SMALL_SLOTS))
        && (count_reg[1] <= scba_pkg::CNT_W'(scba_pkg::MEDIUM_SLOTS))
        && (count_reg[2] <= scba_pkg::CNT_W'(scba_pkg::LARGE_SLOTS)))
        else $error("pool count exceeds slot count");

    a_scan_pool_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (pool_reg < scba_pkg::POOL_W'(scba_pkg::NUM_POOLS)))
        else $error("scan on a nonexistent pool");

    a_grant_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_status_reg == scba_pkg::ST_GRANTED) |-> (res_in_use_reg != '0))
        else $error("grant reported with zero in use");

    a_op_matches_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE) |-> op_reg)
        else $error("free path entered for an allocate request");
`endif

endmodule

@@ hdl/scba_cfg.sv @@
// Configuration register file: enable bit and the three size-class limits.
`timescale 1ns / 1ps

module scba_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scba_pkg::SIZE_W-1:0]    cfg_data,
    output scba_pkg::cfg_t                 cfg
);

    scba_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg            = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled  <= 1'b1;
            cfg_reg.limit[0] <= scba_pkg::SMALL_LIMIT_RST;
            cfg_reg.limit[1] <= scba_pkg::MEDIUM_LIMIT_RST;
            cfg_reg.limit[2] <= scba_pkg::LARGE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scba_pkg::REG_ENABLED:      cfg_reg.enabled  <= cfg_data[0];
                scba_pkg::REG_SMALL_LIMIT:  cfg_reg.limit[0] <= cfg_data;
                scba_pkg::REG_MEDIUM_LIMIT: cfg_reg.limit[1] <= cfg_data;
                scba_pkg::REG_LARGE_LIMIT:  cfg_reg.limit[2] <= cfg_data;
                default:                    cfg_reg          <= cfg_reg;
            endcase
        end
    end

endmodule

@@ hdl/scba_scan.sv @@
// Find-first-free unit: lowest clear busy bit among the valid lanes of one word.
`timescale 1ns / 1ps

module scba_scan (
    input  logic [scba_pkg::LANE_N-1:0] word,
    input  logic [scba_pkg::LANE_N-1:0] mask,
    output logic                        found,
    output logic [scba_pkg::LANE_W-1:0] idx
);

    logic [scba_pkg::LANE_N-1:0] free_lanes;

    assign free_lanes = ~word & mask;

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        // walk down so the lowest free lane wins
        for (int b = scba_pkg::LANE_N - 1; b >= 0; b--)
        begin
            if (free_lanes[b])
            begin
                found = 1'b1;
                idx   = scba_pkg::LANE_W'(b);
            end
        end
    end

endmodule
